// File: rtl/assert_macros.svh
// Assertion helpers shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge outside reset
`define FIR_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("fir assertion failed");

// expr must never be true outside reset
`define FIR_ASSERT_NEVER(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("fir forbidden condition seen");

`endif

// File: rtl/fir_pkg.sv
package fir_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int COEF_W           = 16;
  localparam int IDX_W            = 6;
  localparam int TAPCNT_W         = 7;
  localparam int MAX_TAPS_DEFAULT = 64;
  localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = 7'd64;

  // s tdata: sample_in, coef_index, coef_value, padded to whole bytes
  localparam int S_FIELDS_W = SAMPLE_W + IDX_W + COEF_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOAD   = 1'b1
  } fir_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DONE
  } fir_state_t;

  typedef struct packed {
    logic start;     // sample transaction: write delay line, preset accumulator to rounding offset
    logic load;      // coefficient transaction
    logic rd_en;     // read one tap and advance the addresses
    logic out_load;  // capture the rounded result in the output register
  } fir_cmd_t;

  typedef struct packed {
    logic out_free;  // output register empty or being emptied this cycle
  } fir_status_t;

endpackage

// File: rtl/fir_ram.sv
module fir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/fir_ctrl.sv
`include "assert_macros.svh"

module fir_ctrl
  import fir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  input  logic                s_op,
  output logic                s_ready,
  input  logic                cfg_valid,
  input  logic [TAPCNT_W-1:0] cfg_data,
  input  fir_status_t         status,
  output fir_cmd_t            cmd
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  fir_state_t          state, state_next;
  logic [TAPCNT_W-1:0] tap_count;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    n_eff;
  logic                drain;
  logic                take;
  logic                take_sample;

  // tap counts above the store depth clamp to the full depth
  assign n_eff = (32'(tap_count) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(tap_count);

  assign take        = s_valid && s_ready;
  assign take_sample = take && (fir_op_t'(s_op) == OP_SAMPLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_count <= TAPCNT_RESET;
      cnt       <= '0;
      drain     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        tap_count <= cfg_data;
      end
      if (take_sample) begin
        cnt   <= n_eff;
        drain <= 1'b0;
      end else if (state == S_READ) begin
        cnt <= cnt - CNT_W'(1);
      end else if (state == S_DRAIN) begin
        drain <= ~drain;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take_sample) begin
          state_next = (n_eff == '0) ? S_DRAIN : S_READ;
        end
      end
      S_READ: begin
        if (cnt == CNT_W'(1)) begin
          state_next = S_DRAIN;
        end
      end
      // wait for the product and accumulate stages to empty
      S_DRAIN: begin
        if (drain) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_ready      = 1'b0;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        s_ready   = 1'b1;
        cmd.start = take_sample;
        cmd.load  = take && (fir_op_t'(s_op) == OP_LOAD);
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
      end
      S_DRAIN: begin
      end
      S_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: begin
      end
    endcase
  end

  `FIR_ASSERT(a_sample_leaves_idle, clk, rst, take_sample |=> state != S_IDLE)
  `FIR_ASSERT(a_read_count_live, clk, rst, (state == S_READ) |-> (cnt != '0))
  `FIR_ASSERT(a_load_into_free_slot, clk, rst, cmd.out_load |-> status.out_free)

endmodule

// File: rtl/fir_dp.sv
`include "assert_macros.svh"

module fir_dp
  import fir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  fir_cmd_t            cmd,
  output fir_status_t         status,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic [IDX_W-1:0]    coef_index,
  input  logic [COEF_W-1:0]   coef_value,
  output logic                m_valid,
  input  logic                m_ready,
  output logic [SAMPLE_W-1:0] sample_out,
  output logic                saturated
);

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int PROD_W = SAMPLE_W + COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int SHIFT  = COEF_W - 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);
  localparam logic signed [ACC_W-1:0] ROUND_INIT = ACC_W'(2 ** (COEF_W - 2));
  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

  logic [AW-1:0]            head, head_next;
  logic [AW-1:0]            daddr, caddr;
  logic [AW-1:0]            cwaddr;
  logic                     coef_ok;
  logic [MAX_TAPS-1:0]      dvalid, cvalid;
  logic                     v1, v2, dv1, cv1;
  logic [SAMPLE_W-1:0]      d_rdata;
  logic [COEF_W-1:0]        c_rdata;
  logic signed [SAMPLE_W-1:0] d_op;
  logic signed [COEF_W-1:0]   c_op;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  y;
  logic                     sat_hi, sat_lo;

  // newest sample sits at head; tap i lives at head + i, wrapping
  assign head_next = (head == '0) ? LAST_ADDR : head - AW'(1);
  assign coef_ok   = 32'(coef_index) < MAX_TAPS;
  assign cwaddr    = AW'(coef_index);

  fir_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_TAPS)) u_delay_ram (
    .clk   (clk),
    .we    (cmd.start),
    .waddr (head_next),
    .wdata (sample_in),
    .re    (cmd.rd_en),
    .raddr (daddr),
    .rdata (d_rdata)
  );

  fir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (cmd.load && coef_ok),
    .waddr (cwaddr),
    .wdata (coef_value),
    .re    (cmd.rd_en),
    .raddr (caddr),
    .rdata (c_rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      head   <= '0;
      dvalid <= '0;
      cvalid <= '0;
      v1     <= 1'b0;
      v2     <= 1'b0;
    end else begin
      v1 <= cmd.rd_en;
      v2 <= v1;
      if (cmd.start) begin
        head              <= head_next;
        dvalid[head_next] <= 1'b1;
      end
      if (cmd.load && coef_ok) begin
        cvalid[cwaddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      daddr <= head_next;
      caddr <= '0;
    end else if (cmd.rd_en) begin
      daddr <= (daddr == LAST_ADDR) ? '0 : daddr + AW'(1);
      caddr <= caddr + AW'(1);
    end
    if (cmd.rd_en) begin
      dv1 <= dvalid[daddr];
      cv1 <= cvalid[caddr];
    end
  end

  assign d_op = dv1 ? signed'(d_rdata) : '0;
  assign c_op = cv1 ? signed'(c_rdata) : '0;

  // accumulator starts at the rounding offset, so the final step is a shift
  always_ff @(posedge clk) begin
    prod <= d_op * c_op;
    if (cmd.start) begin
      acc <= ROUND_INIT;
    end else if (v2) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign y      = acc >>> SHIFT;
  assign sat_hi = y > Y_MAX;
  assign sat_lo = y < Y_MIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (cmd.out_load) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (sat_hi) begin
        sample_out <= Y_MAX[SAMPLE_W-1:0];
      end else if (sat_lo) begin
        sample_out <= Y_MIN[SAMPLE_W-1:0];
      end else begin
        sample_out <= y[SAMPLE_W-1:0];
      end
      saturated <= sat_hi || sat_lo;
    end
  end

  assign status.out_free = !m_valid || m_ready;

  `FIR_ASSERT_NEVER(a_result_with_mac_in_flight, clk, rst, cmd.out_load && (v1 || v2))
  `FIR_ASSERT(a_result_leaves_only_when_taken, clk, rst, $fell(m_valid) |-> $past(m_ready))

endmodule

// File: rtl/fir_filter_direct_form.sv
// Direct-form FIR filter, Q1.15 samples and taps. An input transaction with
// tuser = 1 writes coef_value to tap coef_index (indexes at or above MAX_TAPS
// are dropped) and produces no output; with tuser = 0 it pushes sample_in into
// the delay line and produces one output: the sum over the first tap_count taps
// of delay times tap, rounded half up, shifted right by 15 and clipped to 16
// bits, with tuser flagging the clip. Delay line and taps reset to zero;
// tap_count resets to 64 and clamps to MAX_TAPS. After a sample is accepted,
// the single multiply-accumulate walks the tap and delay memories one tap per
// cycle, the product and accumulate stages drain and the rounded result goes
// to the output register once it is free. The next item is accepted while the
// previous output still waits for the sink. tap_count writes are taken at once
// and must only occur while the filter is idle.
module fir_filter_direct_form
  import fir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [15:0] sample_in, [21:16] coef_index, [37:22] coef_value, rest zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [0] op
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [15:0] sample_out
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // [0] saturated
  output logic [0:0]           m_axis_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TAPCNT_W-1:0]  cfg_data
);

  fir_cmd_t            cmd;
  fir_status_t         status;
  logic [SAMPLE_W-1:0] sample_out;
  logic                saturated;

  assign cfg_ready = 1'b1;

  fir_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_valid   (s_axis_tvalid),
    .s_op      (s_axis_tuser[0]),
    .s_ready   (s_axis_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  fir_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .sample_in  (s_axis_tdata[SAMPLE_W-1:0]),
    .coef_index (s_axis_tdata[SAMPLE_W+IDX_W-1:SAMPLE_W]),
    .coef_value (s_axis_tdata[S_FIELDS_W-1:SAMPLE_W+IDX_W]),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

  assign m_axis_tdata    = M_TDATA_W'(sample_out);
  assign m_axis_tuser[0] = saturated;

endmodule
